/* hw/rtl/rfpwd_pkg.sv */
// Shared types, register indexes and window compare for the pulse width decoder.
package rfpwd_pkg;

   localparam int TICK_W  = 10;
   localparam int TOL_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam int COUNT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_TOL   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HDR_TOL   = 3'd6;

   localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 10'd77;
   localparam logic [TICK_W-1:0] RST_ONE_LOW   = 10'd22;
   localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 10'd28;
   localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 10'd73;
   localparam logic [TICK_W-1:0] RST_HDR_LOW   = 10'd753;
   localparam logic [TOL_W-1:0]  RST_BIT_TOL   = 8'd10;
   localparam logic [TOL_W-1:0]  RST_HDR_TOL   = 8'd20;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   localparam logic [7:0] CMD_DRIVE_ON  = 8'd0;
   localparam logic [7:0] CMD_DRIVE_OFF = 8'd1;

   typedef struct packed {
      logic [TICK_W-1:0] one_high;
      logic [TICK_W-1:0] one_low;
      logic [TICK_W-1:0] zero_high;
      logic [TICK_W-1:0] zero_low;
      logic [TICK_W-1:0] hdr_low;
      logic [TOL_W-1:0]  bit_tol;
      logic [TOL_W-1:0]  hdr_tol;
   } cfg_type;

   typedef struct packed {
      logic       drive_on;
      logic [7:0] byte_third;
      logic [7:0] byte_second;
      logic [7:0] byte_first;
      logic       frame_done;
   } result_type;

   // t above nom - tol, compared as t + tol > nom to stay unsigned
   function automatic logic above_low(input logic [TICK_W-1:0] t,
                                      input logic [TICK_W-1:0] nom,
                                      input logic [TOL_W-1:0]  tol);
      logic [TICK_W:0] sum;
      sum = {1'b0, t} + {{(TICK_W-TOL_W+1){1'b0}}, tol};
      return sum > {1'b0, nom};
   endfunction

   function automatic logic in_window(input logic [TICK_W-1:0] t,
                                      input logic [TICK_W-1:0] nom,
                                      input logic [TOL_W-1:0]  tol);
      logic [TICK_W:0] hi;
      hi = {1'b0, nom} + {{(TICK_W-TOL_W+1){1'b0}}, tol};
      return above_low(t, nom, tol) && ({1'b0, t} < hi);
   endfunction

endpackage

/* hw/rtl/rf_remote_pulse_width_decoder.sv */
// Top level of the remote control pulse width decoder.
//
// Usage: each req_ transfer carries one finished pulse, req_tuser its level
// (1 high, 0 low) and req_tdata its length in 16 us ticks. Every pulse gives
// exactly one rsp_ transfer: rsp_tuser is 1 when an end code closed a frame,
// rsp_tdata then holds the three received bytes and always the drive state.
// Two register stages: the req_ transfer loads the input register, and the
// output register takes the decoded pulse from it once the output register
// is empty or its item is being taken; rsp_tvalid then rises.
// One pulse is taken per cycle while rsp_tready stays high; the combinational
// decode path sets it.
// When the receiver stalls, the output register holds its item and the input
// register takes one more pulse before req_tready drops.
// Reset clears both stages, the frame state and the drive state, and loads
// the timing registers with their defaults. The csr_ port writes one timing
// register per cycle and is to be used only while no pulse is in flight.
module rf_remote_pulse_width_decoder
   import rfpwd_pkg::*;
#(
   parameter int FRAME_BITS = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [9:0] pulse_ticks
   input  logic                  req_tuser,   // [0] pulse_level
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [7:0] byte_first, [15:8] byte_second,
                                              // [23:16] byte_third, [24] drive_on
   output logic                  rsp_tuser,   // [0] frame_done
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg;
   result_type        result;
   logic              in_valid_ff, in_valid_in;
   logic              in_level_ff;
   logic [TICK_W-1:0] in_ticks_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   logic              advance;
   logic              step;

   rfpwd_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rfpwd_decode #(
      .FRAME_BITS (FRAME_BITS)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .pulse_level (in_level_ff),
      .pulse_ticks (in_ticks_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign step         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_level_ff <= req_tuser;
         in_ticks_ff <= req_tdata[TICK_W-1:0];
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.frame_done;
   assign rsp_tdata  = {7'd0, rsp_ff.drive_on, rsp_ff.byte_third,
                        rsp_ff.byte_second, rsp_ff.byte_first};

endmodule

/* hw/rtl/rfpwd_cfg.sv */
// Timing register file, written through the plain write port.
module rfpwd_cfg
   import rfpwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ONE_HIGH:  cfg_in.one_high  = csr_wdata;
            CSR_ONE_LOW:   cfg_in.one_low   = csr_wdata;
            CSR_ZERO_HIGH: cfg_in.zero_high = csr_wdata;
            CSR_ZERO_LOW:  cfg_in.zero_low  = csr_wdata;
            CSR_HDR_LOW:   cfg_in.hdr_low   = csr_wdata;
            CSR_BIT_TOL:   cfg_in.bit_tol   = csr_wdata[TOL_W-1:0];
            CSR_HDR_TOL:   cfg_in.hdr_tol   = csr_wdata[TOL_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high  <= RST_ONE_HIGH;
         cfg_ff.one_low   <= RST_ONE_LOW;
         cfg_ff.zero_high <= RST_ZERO_HIGH;
         cfg_ff.zero_low  <= RST_ZERO_LOW;
         cfg_ff.hdr_low   <= RST_HDR_LOW;
         cfg_ff.bit_tol   <= RST_BIT_TOL;
         cfg_ff.hdr_tol   <= RST_HDR_TOL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/rfpwd_decode.sv */
// Frame state and per-pulse decode: windows, bit shifting, byte latching, end code.
module rfpwd_decode
   import rfpwd_pkg::*;
#(
   parameter int FRAME_BITS = 24
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              pulse_level,
   input  logic [TICK_W-1:0] pulse_ticks,
   input  cfg_type           cfg,
   output result_type        result
);

   logic               receiving_ff, receiving_in;
   logic               pend_one_ff, pend_one_in;
   logic               pend_zero_ff, pend_zero_in;
   logic               drive_ff, drive_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         shift_ff, shift_in;
   logic [7:0]         held_ff [3];
   logic [7:0]         held_in [3];

   logic               win_one_hi, win_zero_hi, win_one_lo, win_zero_lo;
   logic               win_hdr, end_len, take, bit_val, done;
   logic [7:0]         base;
   logic [7:0]         bit_word;
   logic [COUNT_W-1:0] count_inc;

   always_comb begin
      win_one_hi  = in_window(pulse_ticks, cfg.one_high, cfg.bit_tol);
      win_zero_hi = in_window(pulse_ticks, cfg.zero_high, cfg.bit_tol);
      win_one_lo  = in_window(pulse_ticks, cfg.one_low, cfg.bit_tol);
      win_zero_lo = in_window(pulse_ticks, cfg.zero_low, cfg.bit_tol);
      win_hdr     = in_window(pulse_ticks, cfg.hdr_low, cfg.hdr_tol);
      end_len     = above_low(pulse_ticks, cfg.hdr_low, cfg.bit_tol);
   end

   always_comb begin
      receiving_in = receiving_ff;
      pend_one_in  = pend_one_ff;
      pend_zero_in = pend_zero_ff;
      drive_in     = drive_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      held_in      = held_ff;
      take         = 1'b0;
      bit_val      = 1'b0;
      done         = 1'b0;

      if (pulse_level) begin
         if (receiving_ff) begin
            pend_one_in  = win_one_hi;
            pend_zero_in = !win_one_hi && win_zero_hi;
         end
      end else if (receiving_ff) begin
         if (win_one_lo && pend_one_ff) begin
            take    = 1'b1;
            bit_val = 1'b1;
         end else if (!win_one_lo && win_zero_lo && pend_zero_ff) begin
            take = 1'b1;
         end else begin
            receiving_in = 1'b0;
            pend_one_in  = 1'b0;
            pend_zero_in = 1'b0;
            count_in     = '0;
            if (!win_one_lo && !win_zero_lo && pend_zero_ff && end_len) begin
               done = 1'b1;
               if (held_ff[2] == CMD_DRIVE_ON) begin
                  drive_in = 1'b1;
               end else if (held_ff[2] == CMD_DRIVE_OFF) begin
                  drive_in = 1'b0;
               end
            end
         end
      end else if (win_hdr) begin
         receiving_in = 1'b1;
         pend_one_in  = 1'b0;
         pend_zero_in = 1'b0;
         count_in     = '0;
      end

      // first bit of a frame starts from cleared bytes
      base      = (count_ff == '0) ? 8'd0 : shift_ff;
      bit_word  = base | {7'd0, bit_val};
      count_inc = (count_ff < COUNT_MAX) ? count_ff + 5'd1 : count_ff;

      if (take) begin
         count_in = count_inc;
         shift_in = {bit_word[6:0], 1'b0};
         if (count_ff == '0) begin
            held_in[0] = 8'd0;
            held_in[1] = 8'd0;
            held_in[2] = 8'd0;
         end
         for (int k = 0; k < 3; k++) begin
            if ((count_inc == COUNT_W'(8 * (k + 1))) && (8 * (k + 1) <= FRAME_BITS)) begin
               held_in[k] = bit_word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         pend_one_ff  <= 1'b0;
         pend_zero_ff <= 1'b0;
         drive_ff     <= 1'b0;
         count_ff     <= '0;
         shift_ff     <= '0;
         held_ff[0]   <= '0;
         held_ff[1]   <= '0;
         held_ff[2]   <= '0;
      end else if (step) begin
         receiving_ff <= receiving_in;
         pend_one_ff  <= pend_one_in;
         pend_zero_ff <= pend_zero_in;
         drive_ff     <= drive_in;
         count_ff     <= count_in;
         shift_ff     <= shift_in;
         held_ff      <= held_in;
      end
   end

   always_comb begin
      result.frame_done  = done;
      result.byte_first  = done ? held_ff[0] : 8'd0;
      result.byte_second = done ? held_ff[1] : 8'd0;
      result.byte_third  = done ? held_ff[2] : 8'd0;
      result.drive_on    = drive_in;
   end

endmodule

/* hw/rtl/rfpwd_checker.sv */
// Port-level checks on the decoder, bound to the top level.
module rfpwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled transfer changed");

   a_bytes_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[23:0] == 24'd0)
      else $error("bytes nonzero without a finished frame");

   a_drive_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && (rsp_tdata[23:16] == 8'd0 || rsp_tdata[23:16] == 8'd1)
      |-> rsp_tdata[24] == (rsp_tdata[23:16] == 8'd0))
      else $error("drive state does not follow command byte");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && rsp_tvalid && !rsp_tready && $past(rsp_tvalid && !rsp_tready)
      && $past(req_tvalid && req_tready) |-> !req_tready)
      else $error("input taken with both stages full");

endmodule

bind rf_remote_pulse_width_decoder rfpwd_checker u_rfpwd_checker (.*);
